@@ rtl/core/bsfp_pkg.sv @@
// Shared types and constants of the bulk string frame parser.
package bsfp_pkg;

    // Length counter width default and reset value of the length limit
    localparam int LEN_WIDTH_DEF = 16;
    localparam int CFG_WIDTH     = 16;
    localparam logic [CFG_WIDTH-1:0] MAX_LEN_RESET = 16'hFFFF;

    // Framing characters
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Line-end and trailer byte counts
    localparam logic [1:0] SKIP_PAIR = 2'd2;
    localparam logic [1:0] SKIP_ONE  = 2'd1;

    typedef enum logic [3:0] {
        PH_WAIT_HASH,
        PH_COUNT,
        PH_HDR_LE,
        PH_DOLLAR,
        PH_LEN_FIRST,
        PH_LEN_MORE,
        PH_LEN_LE,
        PH_PAYLOAD,
        PH_TRAIL
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_HASH   = 3'd1,
        ERR_COUNT     = 3'd2,
        ERR_NO_DOLLAR = 3'd3,
        ERR_LENGTH    = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [1:0] field_index;
        logic       field_last;
        logic       field_empty;
        logic       message_done;
        t_err       error_code;
    } t_result;

endpackage

@@ rtl/core/bulk_string_frame_parser_unit.sv @@
// Top level of the bulk string frame parser: byte-wide request framing decoder.

// Parses '#' <count> CR LF, then per element '$' <length> CR LF <payload> CR LF,
// one byte per transaction. Each payload byte leaves on the master side with
// tlast on the last byte of its field; tuser tells the field (0 command, 1 key,
// 2 value), flags empty fields, end of message and faults. A fault restarts the
// search for '#'. Throughput is one byte per clock: the phase decoder and the
// length accumulate/compare sit between the parse state registers and a
// two-deep result stage (output register plus skid register), so the slave side
// only stalls once both result registers are full. Every result is registered.
// The length limit is to be written through i_cfg_wr_en / i_cfg_wr_data only
// while the block is idle: a rule for the user, not enforced by the block.
module bulk_string_frame_parser_unit #(
    parameter int LEN_WIDTH = bsfp_pkg::LEN_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: length limit
    input  logic                           i_cfg_wr_en,
    input  logic [bsfp_pkg::CFG_WIDTH-1:0] i_cfg_wr_data,
    // slave side
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [7:0] data_byte
    // master side
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [7:0]                     o_m_tdata,   // [7:0] payload_byte
    output logic [7:0]                     o_m_tuser,   // [0] payload_valid,
                                                        // [2:1] field_index,
                                                        // [3] field_empty,
                                                        // [4] message_done,
                                                        // [7:5] error_code
    output logic                           o_m_tlast    // field_last
);

    localparam int CW = (LEN_WIDTH > bsfp_pkg::CFG_WIDTH) ? LEN_WIDTH : bsfp_pkg::CFG_WIDTH;
    localparam int VW = LEN_WIDTH + 4;

    // ---- parse state ----
    bsfp_pkg::t_phase              r_phase, n_phase;
    logic [1:0]                    r_elem_total, n_elem_total;
    logic [1:0]                    r_elem_num, n_elem_num;
    logic [LEN_WIDTH-1:0]          r_len_acc, n_len_acc;
    logic [LEN_WIDTH-1:0]          r_bytes_rem, n_bytes_rem;
    logic [1:0]                    r_skip, n_skip;
    logic [bsfp_pkg::CFG_WIDTH-1:0] r_max_len;

    // ---- result stage ----
    logic                 r_out_valid, r_skid_valid;
    bsfp_pkg::t_result    r_out, r_skid;
    bsfp_pkg::t_result    res;
    logic                 res_valid;

    logic                 accept;
    logic                 is_digit;
    logic [1:0]           skip_dec;
    logic [CW-1:0]        max_ext, mask_ext;
    logic [LEN_WIDTH-1:0] limit;
    logic [VW-1:0]        len_next;
    logic                 too_long;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_skid_valid;

    // Length limit clipped to the counter range
    assign max_ext  = CW'(r_max_len);
    assign mask_ext = CW'({LEN_WIDTH{1'b1}});
    assign limit    = (max_ext < mask_ext) ? max_ext[LEN_WIDTH-1:0] : {LEN_WIDTH{1'b1}};

    // acc * 10 + digit, kept wide enough not to wrap
    assign len_next = VW'({r_len_acc, 3'b000}) + VW'({r_len_acc, 1'b0})
                    + VW'(i_s_tdata[3:0] - bsfp_pkg::CH_ZERO[3:0]);
    assign too_long = len_next > VW'(limit);
    assign skip_dec = r_skip - 2'd1;

    always_comb begin
        is_digit = i_s_tdata inside {[bsfp_pkg::CH_ZERO:bsfp_pkg::CH_NINE]};
    end

    // ---- next state ----
    always_comb begin
        n_phase      = r_phase;
        n_elem_total = r_elem_total;
        n_elem_num   = r_elem_num;
        n_len_acc    = r_len_acc;
        n_bytes_rem  = r_bytes_rem;
        n_skip       = r_skip;
        case (r_phase)
            bsfp_pkg::PH_WAIT_HASH: begin
                if (i_s_tdata == bsfp_pkg::CH_HASH) begin
                    n_phase    = bsfp_pkg::PH_COUNT;
                    n_elem_num = 2'd0;
                end
            end
            bsfp_pkg::PH_COUNT: begin
                if (i_s_tdata inside {bsfp_pkg::CH_TWO, bsfp_pkg::CH_THREE}) begin
                    n_elem_total = i_s_tdata[1:0] ^ bsfp_pkg::CH_ZERO[1:0];
                    n_elem_num   = 2'd0;
                    n_skip       = bsfp_pkg::SKIP_PAIR;
                    n_phase      = bsfp_pkg::PH_HDR_LE;
                end else begin
                    n_phase = bsfp_pkg::PH_WAIT_HASH;
                end
            end
            bsfp_pkg::PH_HDR_LE: begin
                n_skip = skip_dec;
                if (skip_dec == 2'd0) n_phase = bsfp_pkg::PH_DOLLAR;
            end
            bsfp_pkg::PH_DOLLAR: begin
                if (i_s_tdata == bsfp_pkg::CH_DOLLAR) begin
                    n_len_acc = '0;
                    n_phase   = bsfp_pkg::PH_LEN_FIRST;
                end else begin
                    n_phase = bsfp_pkg::PH_WAIT_HASH;
                end
            end
            bsfp_pkg::PH_LEN_FIRST, bsfp_pkg::PH_LEN_MORE: begin
                if (is_digit) begin
                    if (too_long) begin
                        n_phase = bsfp_pkg::PH_WAIT_HASH;
                    end else begin
                        n_len_acc = len_next[LEN_WIDTH-1:0];
                        n_phase   = bsfp_pkg::PH_LEN_MORE;
                    end
                end else if (r_phase == bsfp_pkg::PH_LEN_FIRST) begin
                    n_phase = bsfp_pkg::PH_WAIT_HASH;
                end else begin
                    // terminator is the first line-end byte
                    n_bytes_rem = r_len_acc;
                    n_skip      = bsfp_pkg::SKIP_ONE;
                    n_phase     = bsfp_pkg::PH_LEN_LE;
                end
            end
            bsfp_pkg::PH_LEN_LE: begin
                n_skip = skip_dec;
                if (skip_dec == 2'd0) begin
                    if (r_bytes_rem == '0) begin
                        n_skip  = bsfp_pkg::SKIP_PAIR;
                        n_phase = bsfp_pkg::PH_TRAIL;
                    end else begin
                        n_phase = bsfp_pkg::PH_PAYLOAD;
                    end
                end
            end
            bsfp_pkg::PH_PAYLOAD: begin
                if (r_bytes_rem <= LEN_WIDTH'(1)) begin
                    n_bytes_rem = '0;
                    n_skip      = bsfp_pkg::SKIP_PAIR;
                    n_phase     = bsfp_pkg::PH_TRAIL;
                end else begin
                    n_bytes_rem = r_bytes_rem - LEN_WIDTH'(1);
                end
            end
            bsfp_pkg::PH_TRAIL: begin
                n_skip = skip_dec;
                if (skip_dec == 2'd0) begin
                    n_elem_num = r_elem_num + 2'd1;
                    if ((r_elem_num + 2'd1) >= r_elem_total) n_phase = bsfp_pkg::PH_WAIT_HASH;
                    else n_phase = bsfp_pkg::PH_DOLLAR;
                end
            end
            default: n_phase = bsfp_pkg::PH_WAIT_HASH;
        endcase
    end

    // ---- result decode ----
    always_comb begin
        res = '0;
        case (r_phase)
            bsfp_pkg::PH_WAIT_HASH: begin
                if (i_s_tdata != bsfp_pkg::CH_HASH) res.error_code = bsfp_pkg::ERR_NO_HASH;
            end
            bsfp_pkg::PH_COUNT: begin
                if (!(i_s_tdata inside {bsfp_pkg::CH_TWO, bsfp_pkg::CH_THREE}))
                    res.error_code = bsfp_pkg::ERR_COUNT;
            end
            bsfp_pkg::PH_DOLLAR: begin
                if (i_s_tdata != bsfp_pkg::CH_DOLLAR) res.error_code = bsfp_pkg::ERR_NO_DOLLAR;
            end
            bsfp_pkg::PH_LEN_FIRST, bsfp_pkg::PH_LEN_MORE: begin
                // over-limit digit, or no digit at all
                if ((is_digit && too_long) || (!is_digit && r_phase == bsfp_pkg::PH_LEN_FIRST))
                    res.error_code = bsfp_pkg::ERR_LENGTH;
            end
            bsfp_pkg::PH_LEN_LE: begin
                if (skip_dec == 2'd0 && r_bytes_rem == '0) begin
                    res.field_index = r_elem_num;
                    res.field_empty = 1'b1;
                end
            end
            bsfp_pkg::PH_PAYLOAD: begin
                res.payload_byte  = i_s_tdata;
                res.payload_valid = 1'b1;
                res.field_index   = r_elem_num;
                res.field_last    = r_bytes_rem <= LEN_WIDTH'(1);
            end
            bsfp_pkg::PH_TRAIL: begin
                if (skip_dec == 2'd0 && (r_elem_num + 2'd1) >= r_elem_total)
                    res.message_done = 1'b1;
            end
            default: res = '0;
        endcase
        res_valid = res.payload_valid || res.field_empty || res.message_done
                 || (res.error_code != bsfp_pkg::ERR_NONE);
    end

    // ---- state registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= bsfp_pkg::PH_WAIT_HASH;
            r_elem_total <= '0;
            r_elem_num   <= '0;
            r_len_acc    <= '0;
            r_bytes_rem  <= '0;
            r_skip       <= '0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_elem_total <= n_elem_total;
            r_elem_num   <= n_elem_num;
            r_len_acc    <= n_len_acc;
            r_bytes_rem  <= n_bytes_rem;
            r_skip       <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= bsfp_pkg::MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    // ---- output register and skid ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_m_tready) begin
            // output stalled: a new result parks in the skid register
            if (accept && res_valid) r_skid_valid <= 1'b1;
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= accept && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_m_tready) begin
            if (accept && res_valid) r_skid <= res;
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.payload_byte;
    assign o_m_tlast  = r_out.field_last;
    assign o_m_tuser  = {r_out.error_code, r_out.message_done, r_out.field_empty,
                         r_out.field_index, r_out.payload_valid};

endmodule

@@ rtl/core/bsfp_checker.sv @@
// Port-level assertions of the bulk string frame parser, bound to the top level.
module bsfp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [7:0] o_m_tuser,
    input logic       o_m_tlast
);

    // stalled transaction holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // slave side only back-pressures while the master side is stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> $past(o_m_tvalid && !i_m_tready))
        else $error("tready low without downstream stall");

    // tlast only on payload bytes, never with a fault
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[0]
            && (o_m_tuser[7:5] == bsfp_pkg::ERR_NONE))
        else $error("tlast on non-payload result");

    // non-payload results carry zero data
    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> (o_m_tdata == 8'd0))
        else $error("data on non-payload result");

endmodule

bind bulk_string_frame_parser_unit bsfp_checker u_bsfp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

@@ tb/tb_bulk_string_frame_parser_unit.sv @@
// Self-checking testbench for the bulk string frame parser: random framed byte streams.
module tb_bulk_string_frame_parser_unit;

    import bsfp_pkg::*;

    // Cycles with no transaction on either side before the run is abandoned
    localparam int QUIET_LIMIT = 1000;

    // Ways of spoiling a generated request
    typedef enum int {
        FLAW_NONE,
        FLAW_COUNT,
        FLAW_DOLLAR,
        FLAW_EMPTY_LEN,
        FLAW_LONG
    } t_flaw;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_WIDTH-1:0] cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic [7:0]           m_tuser;
    logic                 m_tlast;

    // Raw bytes still to be offered on the slave side
    logic [7:0] wire_bytes[$];
    // Results the parser owes us, oldest first
    t_result    parsed_q[$];

    // Parser state as predicted by the testbench
    t_phase      phase;
    logic [1:0]  elem_total;
    logic [1:0]  elem_no;
    logic [15:0] len_acc;
    logic [15:0] bytes_left;
    logic [1:0]  skip_left;
    logic [15:0] length_limit;

    // Stimulus side view of the limit, and pacing control
    int unsigned stim_limit;
    int unsigned mid_limit;
    bit          calm = 1'b0;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned quiet_cycles = 0;

    int unsigned mismatches = 0;
    int unsigned n_bytes = 0;
    int unsigned n_field_bytes = 0;
    int unsigned n_empty = 0;
    int unsigned n_msgs = 0;
    int unsigned n_faults = 0;

    bulk_string_frame_parser_unit u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),   // [7:0] data_byte
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),   // [7:0] payload_byte
        .o_m_tuser     (m_tuser),   // [0] payload_valid, [2:1] field_index,
                                    // [3] field_empty, [4] message_done,
                                    // [7:5] error_code
        .o_m_tlast     (m_tlast)    // field_last
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: one accepted byte in, at most one result queued
    // ------------------------------------------------------------------
    task automatic reset_parser();
        phase        = PH_WAIT_HASH;
        elem_total   = '0;
        elem_no      = '0;
        len_acc      = '0;
        bytes_left   = '0;
        skip_left    = '0;
        length_limit = MAX_LEN_RESET;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        t_result     r;
        logic [19:0] acc_next;
        logic        is_digit;
        r        = '0;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        case (phase)
            PH_WAIT_HASH: begin
                if (b == CH_HASH) begin
                    phase   = PH_COUNT;
                    elem_no = '0;
                end else begin
                    r.error_code = ERR_NO_HASH;
                    phase        = PH_WAIT_HASH;
                end
            end
            PH_COUNT: begin
                if (b == CH_TWO || b == CH_THREE) begin
                    elem_total = b[1:0];   // ASCII '2'/'3' carry the count in the low bits
                    elem_no    = '0;
                    skip_left  = SKIP_PAIR;
                    phase      = PH_HDR_LE;
                end else begin
                    r.error_code = ERR_COUNT;
                    phase        = PH_WAIT_HASH;
                end
            end
            PH_HDR_LE: begin
                skip_left = skip_left - 2'd1;
                if (skip_left == '0)
                    phase = PH_DOLLAR;
            end
            PH_DOLLAR: begin
                if (b == CH_DOLLAR) begin
                    len_acc = '0;
                    phase   = PH_LEN_FIRST;
                end else begin
                    r.error_code = ERR_NO_DOLLAR;
                    phase        = PH_WAIT_HASH;
                end
            end
            PH_LEN_FIRST, PH_LEN_MORE: begin
                if (is_digit) begin
                    acc_next = 20'(len_acc) * 20'd10 + 20'(b - CH_ZERO);
                    // fault on the very digit that takes the length past the limit
                    if (acc_next > 20'(length_limit)) begin
                        r.error_code = ERR_LENGTH;
                        phase        = PH_WAIT_HASH;
                    end else begin
                        len_acc = acc_next[15:0];
                        phase   = PH_LEN_MORE;
                    end
                end else if (phase == PH_LEN_FIRST) begin
                    r.error_code = ERR_LENGTH;
                    phase        = PH_WAIT_HASH;
                end else begin
                    // the terminating non-digit is the first line-end byte
                    bytes_left = len_acc;
                    skip_left  = SKIP_ONE;
                    phase      = PH_LEN_LE;
                end
            end
            PH_LEN_LE: begin
                skip_left = skip_left - 2'd1;
                if (skip_left == '0) begin
                    if (bytes_left == '0) begin
                        r.field_index = elem_no;
                        r.field_empty = 1'b1;
                        skip_left     = SKIP_PAIR;
                        phase         = PH_TRAIL;
                    end else begin
                        phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                r.field_index   = elem_no;
                if (bytes_left <= 16'd1) begin
                    r.field_last = 1'b1;
                    bytes_left   = '0;
                    skip_left    = SKIP_PAIR;
                    phase        = PH_TRAIL;
                end else begin
                    bytes_left = bytes_left - 16'd1;
                end
            end
            PH_TRAIL: begin
                skip_left = skip_left - 2'd1;
                if (skip_left == '0) begin
                    elem_no = elem_no + 2'd1;
                    if (elem_no >= elem_total) begin
                        r.message_done = 1'b1;
                        phase          = PH_WAIT_HASH;
                    end else begin
                        phase = PH_DOLLAR;
                    end
                end
            end
            default: phase = PH_WAIT_HASH;
        endcase
        if (r.payload_valid || r.field_empty || r.message_done || r.error_code != ERR_NONE)
            parsed_q = {parsed_q, r};
    endtask

    function automatic int field_diff(string name, int unsigned want, int unsigned got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        return 1;
    endfunction

    task automatic check_result();
        t_result got;
        t_result want;
        int      bad;
        got.payload_byte  = m_tdata;
        got.payload_valid = m_tuser[0];
        got.field_index   = m_tuser[2:1];
        got.field_last    = m_tlast;
        got.field_empty   = m_tuser[3];
        got.message_done  = m_tuser[4];
        got.error_code    = t_err'(m_tuser[7:5]);
        if (parsed_q.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            mismatches++;
        end else begin
            want = parsed_q.pop_front();
            bad  = field_diff("payload_byte", want.payload_byte, got.payload_byte);
            bad += field_diff("payload_valid", want.payload_valid, got.payload_valid);
            bad += field_diff("field_index", want.field_index, got.field_index);
            bad += field_diff("field_last", want.field_last, got.field_last);
            bad += field_diff("field_empty", want.field_empty, got.field_empty);
            bad += field_diff("message_done", want.message_done, got.message_done);
            bad += field_diff("error_code", int'(want.error_code), int'(got.error_code));
            if (bad != 0)
                mismatches++;
            n_field_bytes += want.payload_valid;
            n_empty       += want.field_empty;
            n_msgs        += want.message_done;
            n_faults      += (want.error_code != ERR_NONE);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: mirrors register writes, predicts on slave transactions,
    // checks master transactions. Prediction runs first so a result can
    // never overtake its own expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            reset_parser();
        end else begin
            if (cfg_wr_en)
                length_limit = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata);
                n_bytes++;
            end
            if (m_tvalid && m_tready)
                check_result();
        end
    end

    // ------------------------------------------------------------------
    // Driver: slave side fed from wire_bytes, master side back-pressure
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid   <= 1'b0;
            m_tready   <= 1'b0;
            send_gap   = 0;
            stall_left = 0;
        end else begin
            // only move on once the current transaction has gone through
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (wire_bytes.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= wire_bytes.pop_front();
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: gives up after a long stretch with no transaction at all
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        wire_bytes = {wire_bytes, b};
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic logic [7:0] any_non_digit();
        logic [7:0] b;
        b = 8'($urandom_range(0, 245));
        if (b >= CH_ZERO)
            b = b + 8'd10;
        return b;
    endfunction

    // Line-end bytes go unchecked, so now and then send rubbish there
    function automatic logic [7:0] line_end(input bit second);
        if ($urandom_range(0, 9) < 8)
            return second ? 8'h0A : 8'h0D;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned pick_len();
        int unsigned cap;
        cap = ($urandom_range(0, 9) == 0) ? 24 : 6;
        if (cap > stim_limit)
            cap = stim_limit;
        if ($urandom_range(0, 9) == 0)
            return cap;
        return $urandom_range(0, cap);
    endfunction

    task automatic add_frame(input t_flaw flaw);
        int unsigned n_elem;
        int unsigned bad_at;
        int unsigned len;
        int unsigned e;
        int unsigned k;
        logic [7:0]  b;
        n_elem = $urandom_range(2, 3);
        bad_at = $urandom_range(0, n_elem - 1);
        add_byte(CH_HASH);
        if (flaw == FLAW_COUNT) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_TWO || b == CH_THREE)
                b = CH_HASH;
            add_byte(b);
            return;
        end
        add_byte(n_elem == 2 ? CH_TWO : CH_THREE);
        add_byte(line_end(1'b0));
        add_byte(line_end(1'b1));
        for (e = 0; e < n_elem; e++) begin
            if (flaw == FLAW_DOLLAR && e == bad_at) begin
                b = 8'($urandom_range(0, 255));
                add_byte(b == CH_DOLLAR ? CH_HASH : b);
                return;
            end
            add_byte(CH_DOLLAR);
            if (flaw == FLAW_EMPTY_LEN && e == bad_at) begin
                add_byte(any_non_digit());
                return;
            end
            if (flaw == FLAW_LONG && e == bad_at)
                len = stim_limit + 1 + $urandom_range(0, 40);
            else
                len = pick_len();
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
                add_byte(CH_ZERO);
            push_text($sformatf("%0d", len));
            // digits past the offending one simply land on a parser hunting for '#'
            if (flaw == FLAW_LONG && e == bad_at)
                return;
            add_byte($urandom_range(0, 9) < 8 ? 8'h0D : any_non_digit());
            add_byte(line_end(1'b1));
            for (k = 0; k < len; k++)
                add_byte(8'($urandom_range(0, 255)));
            add_byte(line_end(1'b0));
            add_byte(line_end(1'b1));
        end
    endtask

    // Mostly clean requests with random content, some spoilt ones, a little noise
    task automatic fill_random(input int unsigned n);
        int unsigned start;
        int unsigned r;
        start = wire_bytes.size();
        while (wire_bytes.size() - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 72)
                add_frame(FLAW_NONE);
            else if (r < 92)
                add_frame(t_flaw'($urandom_range(FLAW_COUNT, FLAW_LONG)));
            else
                repeat ($urandom_range(1, 3))
                    add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Idle means: nothing left to send, nothing owed, and a few spare
    // cycles for a byte that produced no result to clear the pipeline
    task automatic wait_drained();
        do
            @(negedge clk);
        while (wire_bytes.size() != 0 || s_tvalid || parsed_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_length_limit(input int unsigned v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_WIDTH'(v);
        stim_limit  = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        stim_limit = MAX_LEN_RESET;
        mid_limit  = $urandom_range(2, 30);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: stray bytes at both extremes, a '#' that faults as a
        // count and is not re-examined, one empty and one single-byte
        // field ending a message, then a missing '$'.
        add_byte(8'h00);
        add_byte(8'hFF);
        push_text("##2");
        push_text("#2\r\n$0\r\n\r\n$1\r\nZ\r\n");
        push_text("#3\r\nX");
        // reset value of the limit first, no write yet
        fill_random(150);
        wait_drained();

        set_length_limit(0);
        fill_random(80);
        wait_drained();

        // back-to-back stretch with no idling on either side
        calm = 1'b1;
        set_length_limit(1);
        fill_random(80);
        wait_drained();
        calm = 1'b0;

        set_length_limit(mid_limit);
        fill_random(120);
        wait_drained();

        set_length_limit(65534);
        fill_random(80);
        wait_drained();

        set_length_limit(65535);
        fill_random(90);
        wait_drained();
        repeat (8) @(negedge clk);

        if (parsed_q.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, parsed_q.size());
        $display("Run covered %0d bytes: %0d field bytes, %0d empty fields,",
                 n_bytes, n_field_bytes, n_empty);
        $display("  %0d messages and %0d faults; length limits 65535 from reset, 0, 1, %0d,"
                 , n_msgs, n_faults, mid_limit);
        $display("  65534 and 65535");
        if (mismatches == 0 && parsed_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bsfp_pkg.sv
rtl/core/bulk_string_frame_parser_unit.sv
rtl/core/bsfp_checker.sv
tb/tb_bulk_string_frame_parser_unit.sv
